@@ hdl/pfc_pkg.sv @@
// pfc_pkg: shared types and constants of the pixel format converter
// source formats, command kinds and the command word passed front to back
// no dependencies
package pfc_pkg;

  localparam int PALETTE_ENTRIES = 256;
  // command queue depth, a power of two
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [3:0] {
    FMT_RGB8   = 4'd0,
    FMT_BGR8   = 4'd1,
    FMT_RGBX8  = 4'd2,
    FMT_BGRX8  = 4'd3,
    FMT_RGB555 = 4'd4,
    FMT_BGR555 = 4'd5,
    FMT_RGB565 = 4'd6,
    FMT_BGR565 = 4'd7,
    FMT_PAL8   = 4'd8
  } fmt_t;

  typedef enum logic [1:0] {
    KIND_DIRECT = 2'd0,
    KIND_PAL_RD = 2'd1,
    KIND_PAL_WR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  idx;
    logic [31:0] data;
  } cmd_t;

endpackage

@@ hdl/pfc_if.sv @@
// pfc_if: valid/ready channel interfaces of the pixel format converter
// pfc_in_if carries pixel and palette-write beats, pfc_out_if the rgba beats
// no dependencies
interface pfc_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] source_pixel;
  logic [7:0]  palette_index;
  logic [31:0] palette_value;

  modport source (output valid, op, source_pixel, palette_index, palette_value,
                  input ready);
  modport sink (input valid, op, source_pixel, palette_index, palette_value,
                output ready);
endinterface

interface pfc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rgba;

  modport source (output valid, rgba, input ready);
  modport sink (input valid, rgba, output ready);
endinterface

@@ hdl/pfc_front.sv @@
// pfc_front: format register and input side, classifies each beat
// converts direct formats and turns palette beats into read/write commands
// depends on pfc_pkg, pfc_if
module pfc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata,
  pfc_in_if.sink            in_chan,
  input  logic              q_full,
  output logic              push,
  output pfc_pkg::cmd_t     push_cmd
);

  logic [3:0]  fmt_r;
  logic [3:0]  fmt_nxt;
  logic [31:0] px;

  function automatic logic [7:0] widen5(input logic [4:0] x);
    widen5 = {x, x[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] x);
    widen6 = {x, x[5:4]};
  endfunction

  function automatic logic [31:0] pack_rgb(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    pack_rgb = {pfc_pkg::ALPHA_OPAQUE, b, g, r};
  endfunction

  assign fmt_nxt = cfg_we ? cfg_wdata : fmt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= pfc_pkg::FMT_RGB8;
    end else begin
      fmt_r <= fmt_nxt;
    end
  end

  assign in_chan.ready = !q_full;
  assign push          = in_chan.valid && !q_full;
  assign px            = in_chan.source_pixel;

  always_comb begin
    push_cmd.kind = pfc_pkg::KIND_DIRECT;
    push_cmd.idx  = px[7:0];
    push_cmd.data = '0;
    if (in_chan.op) begin
      push_cmd.kind = pfc_pkg::KIND_PAL_WR;
      push_cmd.idx  = in_chan.palette_index;
      push_cmd.data = in_chan.palette_value;
    end else begin
      unique case (pfc_pkg::fmt_t'(fmt_r))
        pfc_pkg::FMT_RGB8:   push_cmd.data = {pfc_pkg::ALPHA_OPAQUE, px[23:0]};
        pfc_pkg::FMT_BGR8:   push_cmd.data = pack_rgb(px[23:16], px[15:8], px[7:0]);
        pfc_pkg::FMT_RGBX8:  push_cmd.data = px;
        pfc_pkg::FMT_BGRX8:  push_cmd.data = {px[31:24], px[7:0], px[15:8], px[23:16]};
        pfc_pkg::FMT_RGB555: push_cmd.data = pack_rgb(widen5(px[4:0]), widen5(px[9:5]),
                                                      widen5(px[14:10]));
        pfc_pkg::FMT_BGR555: push_cmd.data = pack_rgb(widen5(px[14:10]), widen5(px[9:5]),
                                                      widen5(px[4:0]));
        pfc_pkg::FMT_RGB565: push_cmd.data = pack_rgb(widen5(px[4:0]), widen6(px[10:5]),
                                                      widen5(px[15:11]));
        pfc_pkg::FMT_BGR565: push_cmd.data = pack_rgb(widen5(px[15:11]), widen6(px[10:5]),
                                                      widen5(px[4:0]));
        pfc_pkg::FMT_PAL8:   push_cmd.kind = pfc_pkg::KIND_PAL_RD;
        default:             push_cmd.data = '0;
      endcase
    end
  end

endmodule

@@ hdl/pfc_queue.sv @@
// pfc_queue: short command queue between front and back
// holds classified commands so either side can stall alone
// depends on pfc_pkg
module pfc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pfc_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output pfc_pkg::cmd_t pop_cmd,
  output logic          not_empty
);

  localparam int PTR_W = (pfc_pkg::QUEUE_DEPTH > 1) ? $clog2(pfc_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(pfc_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(pfc_pkg::QUEUE_DEPTH);

  pfc_pkg::cmd_t    slot_r [pfc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == DEPTH_C);
  assign not_empty = (count_r != '0);
  assign pop_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C) else $error("command queue over depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("pop from empty command queue");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == CNT_W'($past(count_r) + 1'b1)))
    else $error("queue count missed a push");
`endif

endmodule

@@ hdl/pfc_back.sv @@
// pfc_back: palette memory and output register
// executes queued commands in order: palette writes, palette reads, direct beats
// depends on pfc_pkg, pfc_if
module pfc_back #(
  parameter int PALETTE_ENTRIES = pfc_pkg::PALETTE_ENTRIES
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_not_empty,
  input  pfc_pkg::cmd_t q_cmd,
  output logic          pop,
  pfc_out_if.source     out_chan
);

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam logic [8:0] IDX_LIMIT = 9'(PALETTE_ENTRIES);

  logic [31:0]                mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] vld_r, vld_nxt;
  logic [31:0]                rd_q_r;
  logic                       s1_valid_r, s1_valid_nxt;
  logic                       s1_pal_r;
  logic                       s1_hit_r;
  logic [31:0]                s1_direct_r;

  logic          in_range;
  logic [AW-1:0] addr;
  logic          is_wr;
  logic          wr_en;
  logic          rd_en;
  logic          s1_load;
  logic          s1_free;

  assign addr     = q_cmd.idx[AW-1:0];
  assign in_range = ({1'b0, q_cmd.idx} < IDX_LIMIT);
  assign is_wr    = (q_cmd.kind == pfc_pkg::KIND_PAL_WR);
  assign s1_free  = !s1_valid_r || out_chan.ready;
  // writes never occupy the output stage, so they drain even while it stalls
  assign pop      = q_not_empty && (is_wr || s1_free);
  assign wr_en    = pop && is_wr && in_range;
  assign s1_load  = pop && !is_wr;
  assign rd_en    = s1_load && (q_cmd.kind == pfc_pkg::KIND_PAL_RD);

  always_comb begin
    vld_nxt = vld_r;
    if (wr_en) begin
      vld_nxt[addr] = 1'b1;
    end
    s1_valid_nxt = s1_valid_r;
    if (s1_free) begin
      s1_valid_nxt = s1_load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      vld_r      <= vld_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= q_cmd.data;
    end
    if (rd_en) begin
      rd_q_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_pal_r    <= (q_cmd.kind == pfc_pkg::KIND_PAL_RD);
      s1_hit_r    <= in_range && vld_r[addr];
      s1_direct_r <= q_cmd.data;
    end
  end

  assign out_chan.valid = s1_valid_r;
  // entries never written since reset read as zero
  assign out_chan.rgba  = s1_pal_r ? (s1_hit_r ? rd_q_r : 32'd0) : s1_direct_r;

`ifndef SYNTHESIS
  a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> vld_r[$past(addr)]) else $error("palette write left entry invalid");

  a_stall_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_chan.ready) |-> !s1_load)
    else $error("output stage loaded while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |=> (out_chan.valid && $stable(out_chan.rgba)))
    else $error("rgba beat changed while stalled");
`endif

endmodule

@@ hdl/pixel_format_to_rgba8_converter.sv @@
// Pixel format to RGBA8888 converter, top level.
// Input channel in_chan (valid/ready): op 0 converts source_pixel in the
// format held in the source-format register, op 1 writes palette_value to
// palette entry palette_index and produces no result beat.
// Output channel out_chan (valid/ready): one rgba beat per op 0 beat, in order.
// cfg_we/cfg_wdata write the source-format register; write it only while the
// block is idle.
// A pixel accepted on in_chan is registered in the command queue and then in
// the output register that drives out_chan. Throughput: one beat per clock
// while out_chan is ready, set by the single-port palette memory that serves
// one read or one write per cycle from the command queue.
// A two-entry command queue parts input from output: input keeps flowing while
// a result waits, and a palette write at the head of the queue drains even when
// the receiver stalls; when the queue fills, in_chan.ready drops.
// Reset: synchronous, active low. Format returns to RGB8 and every palette
// entry reads as zero in the cycle after reset; there is no clearing pass.
// Depends on pfc_pkg, pfc_if, pfc_front, pfc_queue, pfc_back.
module pixel_format_to_rgba8_converter #(
  parameter int PALETTE_ENTRIES = pfc_pkg::PALETTE_ENTRIES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  pfc_in_if.sink     in_chan,
  pfc_out_if.source  out_chan
);

  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_not_empty;
  pfc_pkg::cmd_t push_cmd;
  pfc_pkg::cmd_t pop_cmd;

  pfc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  pfc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .not_empty (q_not_empty)
  );

  pfc_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_cmd       (pop_cmd),
    .pop         (pop),
    .out_chan    (out_chan)
  );

endmodule

@@ tb/sv/tb_top.sv @@
// tb_top: self-checking bench for pixel_format_to_rgba8_converter
// predicts rgba beats for every source format, palette writes and unknown formats
// depends on pfc_pkg, pfc_if and the converter top level
`timescale 1ns / 100ps

module tb_top;

  localparam logic       OP_CONVERT    = 1'b0;
  localparam logic       OP_PAL_WRITE  = 1'b1;
  localparam logic [3:0] FMT_UNUSED_LO = 4'd9;
  localparam logic [3:0] FMT_UNUSED_HI = 4'd15;
  localparam int         SETTLE_CYCLES = 6;
  localparam int         STALL_LIMIT   = 2000;
  localparam int         REPORT_LIMIT  = 10;

  typedef struct {
    logic [31:0] rgba;
    logic [31:0] px;
    logic [3:0]  fmt;
  } rgba_due_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [3:0] cfg_wdata;

  pfc_in_if  in_bus ();
  pfc_out_if out_bus ();

  pixel_format_to_rgba8_converter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_bus.sink),
    .out_chan (out_bus.source)
  );

  // bench copy of the block state
  logic [3:0]  fmt_copy;
  logic [31:0] pal_copy [pfc_pkg::PALETTE_ENTRIES];
  rgba_due_t   rgba_due [$];

  bit tx_gaps_on;
  bit rx_stalls_on;
  int out_stall;
  int errors;
  int reported;
  int pixels_checked;
  int pal_writes_sent;
  int format_writes;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] grow5(logic [4:0] x);
    return {x, x[4:2]};
  endfunction

  function automatic logic [7:0] grow6(logic [5:0] x);
    return {x, x[5:4]};
  endfunction

  function automatic logic [31:0] to_rgba(logic [3:0] f, logic [31:0] px);
    case (f)
      pfc_pkg::FMT_RGB8:   return {pfc_pkg::ALPHA_OPAQUE, px[23:0]};
      pfc_pkg::FMT_BGR8:   return {pfc_pkg::ALPHA_OPAQUE, px[7:0], px[15:8], px[23:16]};
      pfc_pkg::FMT_RGBX8:  return px;
      pfc_pkg::FMT_BGRX8:  return {px[31:24], px[7:0], px[15:8], px[23:16]};
      pfc_pkg::FMT_RGB555: return {pfc_pkg::ALPHA_OPAQUE, grow5(px[14:10]), grow5(px[9:5]),
                                   grow5(px[4:0])};
      pfc_pkg::FMT_BGR555: return {pfc_pkg::ALPHA_OPAQUE, grow5(px[4:0]), grow5(px[9:5]),
                                   grow5(px[14:10])};
      pfc_pkg::FMT_RGB565: return {pfc_pkg::ALPHA_OPAQUE, grow5(px[15:11]), grow6(px[10:5]),
                                   grow5(px[4:0])};
      pfc_pkg::FMT_BGR565: return {pfc_pkg::ALPHA_OPAQUE, grow5(px[4:0]), grow6(px[10:5]),
                                   grow5(px[15:11])};
      pfc_pkg::FMT_PAL8:   return pal_copy[px[7:0]];
      default:             return 32'h0;
    endcase
  endfunction

  // input side: track palette writes and queue the expected rgba for each pixel beat
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready) begin
      if (in_bus.op == OP_PAL_WRITE) begin
        pal_copy[in_bus.palette_index] = in_bus.palette_value;
      end else begin
        rgba_due.push_back('{to_rgba(fmt_copy, in_bus.source_pixel),
                             in_bus.source_pixel, fmt_copy});
      end
    end
  end

  // result side: compare each beat against the oldest prediction
  always @(posedge clk) begin
    rgba_due_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      out_stall = rx_stalls_on ? $urandom_range(0, 6) : 0;
      if (rgba_due.size() == 0) begin
        errors++;
        if (reported < REPORT_LIMIT) begin
          reported++;
          $display("unexpected rgba beat %08h with nothing pending", out_bus.rgba);
        end
      end else begin
        want = rgba_due.pop_front();
        pixels_checked++;
        if (out_bus.rgba !== want.rgba) begin
          errors++;
          if (reported < REPORT_LIMIT) begin
            reported++;
            $display("rgba mismatch: format %0d pixel %08h expected %08h got %08h",
                     want.fmt, want.px, want.rgba, out_bus.rgba);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_bus.ready <= 1'b0;
      out_stall--;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles, %0d results pending",
               quiet_cycles, rgba_due.size());
      $display("pixel_format_to_rgba8_converter verification failed");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_beat(input logic op, input logic [31:0] px,
                           input logic [7:0] idx, input logic [31:0] val);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.op            <= op;
    in_bus.source_pixel  <= px;
    in_bus.palette_index <= idx;
    in_bus.palette_value <= val;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  task automatic send_pixel(input logic [31:0] px);
    send_beat(OP_CONVERT, px, 8'($urandom()), $urandom());
  endtask

  task automatic send_pal_write(input logic [7:0] idx, input logic [31:0] val);
    pal_writes_sent++;
    send_beat(OP_PAL_WRITE, $urandom(), idx, val);
  endtask

  // hold the sender until every pending rgba beat is back and writes have drained
  task automatic wait_idle();
    if (in_bus.valid) begin
      in_bus.valid <= 1'b0;
    end
    while (rgba_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_format(input logic [3:0] f);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= f;
    fmt_copy  = f;
    format_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // palette clears at reset, so lookups before any write read zero
  task automatic test_palette_reset();
    set_format(pfc_pkg::FMT_PAL8);
    send_pixel(32'hDEAD_BE00);
    send_pixel(32'hFFFF_FFFF);
  endtask

  task automatic test_palette_rw();
    set_format(pfc_pkg::FMT_PAL8);
    send_pal_write(8'h00, 32'h1234_5678);
    send_pal_write(8'hFF, 32'hFFFF_FFFF);
    // upper bytes of the pixel must not affect the lookup
    send_pixel(32'hFFFF_FF00);
    send_pixel(32'h0000_00FF);
  endtask

  task automatic test_direct_formats();
    logic [3:0] f;
    for (int i = pfc_pkg::FMT_RGB8; i <= pfc_pkg::FMT_BGR565; i++) begin
      f = 4'(i);
      set_format(f);
      send_pixel((i % 2 == 0) ? 32'hFFFF_FFFF : 32'h0000_0000);
      send_pixel(32'h8421_7BDE);
    end
  endtask

  task automatic test_unknown_formats();
    set_format(FMT_UNUSED_LO);
    send_pixel(32'hFFFF_FFFF);
    set_format(FMT_UNUSED_HI);
    send_pixel(32'hA5A5_5A5A);
  endtask

  task automatic test_random_phases();
    logic [3:0] plan [13] = '{pfc_pkg::FMT_PAL8, pfc_pkg::FMT_RGB8, pfc_pkg::FMT_BGR8,
                              pfc_pkg::FMT_RGBX8, pfc_pkg::FMT_BGRX8, pfc_pkg::FMT_RGB555,
                              pfc_pkg::FMT_BGR555, pfc_pkg::FMT_RGB565, pfc_pkg::FMT_BGR565,
                              FMT_UNUSED_HI, pfc_pkg::FMT_PAL8, FMT_UNUSED_LO,
                              pfc_pkg::FMT_PAL8};
    bit pal_heavy;
    for (int p = 0; p < 13; p++) begin
      set_format(plan[p]);
      tx_gaps_on   = (p % 3 != 2);
      rx_stalls_on = (p % 4 != 3);
      pal_heavy    = (plan[p] == pfc_pkg::FMT_PAL8);
      for (int k = 0; k < 102; k++) begin
        if ($urandom_range(0, 3) == 0 || (pal_heavy && $urandom_range(0, 2) == 0)) begin
          send_pal_write(8'($urandom()), $urandom());
        end else begin
          send_pixel($urandom());
        end
        if ($urandom_range(0, 59) == 0) begin
          wait_idle();
        end
      end
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = pfc_pkg::FMT_RGB8;
    in_bus.valid         = 1'b0;
    in_bus.op            = OP_CONVERT;
    in_bus.source_pixel  = 32'h0;
    in_bus.palette_index = 8'h0;
    in_bus.palette_value = 32'h0;
    out_bus.ready        = 1'b0;
    fmt_copy             = pfc_pkg::FMT_RGB8;
    tx_gaps_on           = 1'b1;
    rx_stalls_on         = 1'b1;
    out_stall            = 0;
    errors               = 0;
    reported             = 0;
    pixels_checked       = 0;
    pal_writes_sent      = 0;
    format_writes        = 0;
    quiet_cycles         = 0;
    foreach (pal_copy[i]) pal_copy[i] = 32'h0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_palette_reset();
    test_direct_formats();
    test_unknown_formats();
    test_palette_rw();
    test_random_phases();
    wait_idle();

    if (errors > reported) begin
      $display("%0d further mismatches not shown", errors - reported);
    end
    $display("covered %0d checked pixels and %0d palette writes across %0d format settings",
             pixels_checked, pal_writes_sent, format_writes);
    $display("all nine formats plus unknown codes, with and without gaps on both sides");
    if (errors == 0 && rgba_due.size() == 0) begin
      $display("pixel_format_to_rgba8_converter verification clean");
    end else begin
      $display("pixel_format_to_rgba8_converter verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/pfc_pkg.sv
hdl/pfc_if.sv
hdl/pfc_front.sv
hdl/pfc_queue.sv
hdl/pfc_back.sv
hdl/pixel_format_to_rgba8_converter.sv
tb/sv/tb_top.sv
